// ----- rtl/lac_pkg.sv -----
// Package for the layer alpha compositor: channel type, full-scale constant
// and the registered input word. No dependencies.
package lac_pkg;

    typedef logic [7:0] t_chan;

    localparam t_chan C_FULL = 8'd255;
    localparam t_chan C_ZERO = 8'd0;

    typedef struct packed {
        t_chan layer_red;
        t_chan layer_green;
        t_chan layer_blue;
        t_chan layer_alpha;
        logic  visible;
        logic  first_layer;
        logic  last_layer;
    } t_in_word;

endpackage

// ----- rtl/lac_if.sv -----
// Valid/ready channel interfaces for the compositor: layer pixel in,
// composite pixel out. Depends on lac_pkg.
interface lac_in_if;
    logic           valid;
    logic           ready;
    lac_pkg::t_chan layer_red;
    lac_pkg::t_chan layer_green;
    lac_pkg::t_chan layer_blue;
    lac_pkg::t_chan layer_alpha;
    logic           visible;
    logic           first_layer;
    logic           last_layer;

    modport source (output valid, layer_red, layer_green, layer_blue, layer_alpha,
                    visible, first_layer, last_layer, input ready);
    modport sink   (input valid, layer_red, layer_green, layer_blue, layer_alpha,
                    visible, first_layer, last_layer, output ready);
endinterface

interface lac_out_if;
    logic           valid;
    logic           ready;
    lac_pkg::t_chan out_red;
    lac_pkg::t_chan out_green;
    lac_pkg::t_chan out_blue;
    lac_pkg::t_chan out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// ----- rtl/lac_darken.sv -----
// One colour channel of the blend: acc - floor((255 - colour) * alpha / 255).
// Depends on lac_pkg.
module lac_darken (
    input  lac_pkg::t_chan i_acc,
    input  lac_pkg::t_chan i_colour,
    input  lac_pkg::t_chan i_alpha,
    output lac_pkg::t_chan o_acc
);
    logic [7:0]  w_inv;
    logic [15:0] w_prod;
    logic [15:0] w_sum;

    assign w_inv  = lac_pkg::C_FULL - i_colour;
    assign w_prod = 16'(w_inv) * 16'(i_alpha);
    // exact x/255 for x <= 255*255: (x + (x >> 8) + 1) >> 8, never exceeds 16 bits
    assign w_sum  = w_prod + {8'd0, w_prod[15:8]} + 16'd1;
    assign o_acc  = i_acc - w_sum[15:8];
endmodule

// ----- rtl/layer_alpha_compositor.sv -----
// Top level of the front-to-back layer alpha compositor: input register,
// RGBA accumulator, output register. Depends on lac_pkg, lac_if, lac_darken.
//
//  channel | dir | word                          | handshake
//  i_pix   | in  | layer RGBA + visible/first/last | valid & ready
//  o_pix   | out | composite RGBA                | valid & ready
//
// One layer word per clock sustained unless a stalled o_pix holds a last word.
// A word waits in the input register, then updates the accumulator; a last
// word is loaded into the output register together with the accumulator.
// The accumulator loop (clamp, 8x8 multiply, /255, subtract) is combinational.
// Reset (synchronous, active low) empties both registers and sets the
// accumulator to white, transparent. A stalled o_pix only holds back last
// words; non-last words keep flowing through the accumulator.
module layer_alpha_compositor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lac_in_if.sink        i_pix,
    lac_out_if.source     o_pix
);
    // input register
    logic              r_in_vld;
    lac_pkg::t_in_word r_in;

    // accumulator
    lac_pkg::t_chan r_acc_red, r_acc_green, r_acc_blue, r_acc_alpha;
    lac_pkg::t_chan n_acc_red, n_acc_green, n_acc_blue, n_acc_alpha;

    // output register
    logic           r_out_vld;
    lac_pkg::t_chan r_out_red, r_out_green, r_out_blue, r_out_alpha;

    logic           w_adv;
    lac_pkg::t_chan w_base_red, w_base_green, w_base_blue, w_base_alpha;
    logic [8:0]     w_alpha_sum;
    lac_pkg::t_chan w_alpha_app;

    // word in input register moves on unless it is a last word and the
    // output register is still full and stalled
    assign w_adv       = r_in_vld && (!r_in.last_layer || !r_out_vld || o_pix.ready);
    assign i_pix.ready = !r_in_vld || w_adv;

    // first mark starts from white, transparent
    assign w_base_red   = r_in.first_layer ? lac_pkg::C_FULL : r_acc_red;
    assign w_base_green = r_in.first_layer ? lac_pkg::C_FULL : r_acc_green;
    assign w_base_blue  = r_in.first_layer ? lac_pkg::C_FULL : r_acc_blue;
    assign w_base_alpha = r_in.first_layer ? lac_pkg::C_ZERO : r_acc_alpha;

    // applied alpha: zero for hidden layers or a saturated pixel, else clamped
    // so the accumulated alpha tops out at full scale
    assign w_alpha_sum = {1'b0, w_base_alpha} + {1'b0, r_in.layer_alpha};

    always_comb begin
        if (!r_in.visible || w_base_alpha == lac_pkg::C_FULL) begin
            w_alpha_app = lac_pkg::C_ZERO;
        end else if (w_alpha_sum > {1'b0, lac_pkg::C_FULL}) begin
            w_alpha_app = lac_pkg::C_FULL - w_base_alpha;
        end else begin
            w_alpha_app = r_in.layer_alpha;
        end
    end

    lac_darken u_dk_red (
        .i_acc(w_base_red), .i_colour(r_in.layer_red), .i_alpha(w_alpha_app),
        .o_acc(n_acc_red)
    );
    lac_darken u_dk_green (
        .i_acc(w_base_green), .i_colour(r_in.layer_green), .i_alpha(w_alpha_app),
        .o_acc(n_acc_green)
    );
    lac_darken u_dk_blue (
        .i_acc(w_base_blue), .i_colour(r_in.layer_blue), .i_alpha(w_alpha_app),
        .o_acc(n_acc_blue)
    );

    assign n_acc_alpha = w_base_alpha + w_alpha_app;

    // control and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_acc_red   <= lac_pkg::C_FULL;
            r_acc_green <= lac_pkg::C_FULL;
            r_acc_blue  <= lac_pkg::C_FULL;
            r_acc_alpha <= lac_pkg::C_ZERO;
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv && r_in.last_layer) begin
                r_out_vld <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_adv) begin
                r_acc_red   <= n_acc_red;
                r_acc_green <= n_acc_green;
                r_acc_blue  <= n_acc_blue;
                r_acc_alpha <= n_acc_alpha;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in.layer_red   <= i_pix.layer_red;
            r_in.layer_green <= i_pix.layer_green;
            r_in.layer_blue  <= i_pix.layer_blue;
            r_in.layer_alpha <= i_pix.layer_alpha;
            r_in.visible     <= i_pix.visible;
            r_in.first_layer <= i_pix.first_layer;
            r_in.last_layer  <= i_pix.last_layer;
        end
        if (w_adv && r_in.last_layer) begin
            r_out_red   <= n_acc_red;
            r_out_green <= n_acc_green;
            r_out_blue  <= n_acc_blue;
            r_out_alpha <= n_acc_alpha;
        end
    end

    assign o_pix.valid     = r_out_vld;
    assign o_pix.out_red   = r_out_red;
    assign o_pix.out_green = r_out_green;
    assign o_pix.out_blue  = r_out_blue;
    assign o_pix.out_alpha = r_out_alpha;

`ifndef SYNTHESIS
    // colour lost since white never exceeds alpha gained
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_red >= lac_pkg::C_FULL - r_acc_alpha) &&
        (r_acc_green >= lac_pkg::C_FULL - r_acc_alpha) &&
        (r_acc_blue >= lac_pkg::C_FULL - r_acc_alpha))
        else $error("accumulated colour below transparency bound");

    // saturated pixel is frozen until the next first mark
    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in.first_layer && r_acc_alpha == lac_pkg::C_FULL) |=>
        (r_acc_alpha == lac_pkg::C_FULL) && $stable(r_acc_red) &&
        $stable(r_acc_green) && $stable(r_acc_blue))
        else $error("saturated accumulator changed");

    // a consumed last word always yields a result
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.last_layer) |=> r_out_vld)
        else $error("last word did not produce a result");
`endif
endmodule
